[design/rrts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared constants and types for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned TASK_COUNT = 8;
  localparam int unsigned IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned RUN_OUT_W  = 3;
  localparam int unsigned MASK_OUT_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_DELAY  = 2'd1,
    OP_SWITCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SWITCH,
    ST_DONE
  } state_e;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [TICK_W-1:0] tick_t;

endpackage
`default_nettype wire

[design/round_robin_task_scheduler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin scheduler with tick-based task delay; wake times live in a RAM.
// ----------------------------------------------------------------------------
// Sequencing: a delay or unused op goes from idle straight to done; tick
//   walks wake-time RAM entries 1..TASK_COUNT-1, one read per cycle, and
//   ends once the last read is checked; switch probes one candidate per
//   cycle until a ready task is found or every task is tried. One event in
//   flight; a new beat is taken once the result is in the output register.
// Reset: counter, running task and blocked flags clear at once; no sweep.
module round_robin_task_scheduler
  import rrts_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [OP_W-1:0]       op_i,
  input  wire logic [TICK_W-1:0]     delay_ticks_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [RUN_OUT_W-1:0]       running_task_o,
  output logic                       switch_requested_o,
  output logic [MASK_OUT_W-1:0]      ready_mask_o,
  output logic [TICK_W-1:0]          tick_now_o
);

  localparam idx_t LAST_IDX = idx_t'(TASK_COUNT - 1);

  state_e state_q, state_d;

  tick_t                 tick_q, tick_d;
  idx_t                  run_q, run_d;
  logic [TASK_COUNT-1:0] blocked_q, blocked_d;
  logic                  req_q, req_d;
  idx_t                  idx_q, idx_d;
  logic                  iss_q, iss_d;
  logic                  chk_q, chk_d;
  idx_t                  chk_idx_q, chk_idx_d;
  idx_t                  cnt_q, cnt_d;

  logic                  out_valid_q, out_valid_d;
  logic [RUN_OUT_W-1:0]  out_run_q, out_run_d;
  logic                  out_req_q, out_req_d;
  logic [MASK_OUT_W-1:0] out_mask_q, out_mask_d;
  tick_t                 out_tick_q, out_tick_d;

  logic  ram_we;
  idx_t  ram_addr;
  tick_t ram_wdata;
  tick_t ram_rdata;

  logic  accept;
  logic  out_free;
  op_e   op;

  assign op       = op_e'(op_i);
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  rrts_wake_ram #(
    .DEPTH(TASK_COUNT),
    .WIDTH(TICK_W)
  ) u_wake_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op)
            OP_TICK:   state_d = ST_TICK;
            OP_SWITCH: state_d = ST_SWITCH;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_TICK: begin
        if (!iss_q && chk_q) begin
          state_d = ST_DONE;
        end
      end
      ST_SWITCH: begin
        if (!blocked_q[idx_q] || cnt_q == LAST_IDX) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    tick_d      = tick_q;
    run_d       = run_q;
    blocked_d   = blocked_q;
    req_d       = req_q;
    idx_d       = idx_q;
    iss_d       = iss_q;
    chk_d       = 1'b0;
    chk_idx_d   = chk_idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_run_d   = out_run_q;
    out_req_d   = out_req_q;
    out_mask_d  = out_mask_q;
    out_tick_d  = out_tick_q;
    ram_we      = 1'b0;
    ram_addr    = idx_q;
    ram_wdata   = tick_q + delay_ticks_i;
    in_ready_o  = (state_q == ST_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = 1'b0;
          unique case (op)
            OP_TICK: begin
              tick_d = tick_q + 1'b1;
              req_d  = 1'b1;
              idx_d  = idx_t'(1);
              iss_d  = 1'b1;
            end
            OP_DELAY: begin
              if (run_q != '0) begin
                ram_we           = 1'b1;
                ram_addr         = run_q;
                blocked_d[run_q] = 1'b1;
                req_d            = 1'b1;
              end
            end
            OP_SWITCH: begin
              idx_d = (run_q == LAST_IDX) ? '0 : run_q + 1'b1;
              cnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        if (chk_q && blocked_q[chk_idx_q] && ram_rdata == tick_q) begin
          blocked_d[chk_idx_q] = 1'b0;
        end
        if (iss_q) begin
          chk_d     = 1'b1;
          chk_idx_d = idx_q;
          if (idx_q == LAST_IDX) begin
            iss_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_SWITCH: begin
        if (!blocked_q[idx_q]) begin
          run_d = idx_q;
        end else if (cnt_q == LAST_IDX) begin
          run_d = '0;
        end else begin
          idx_d = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_run_d   = RUN_OUT_W'(run_q);
          out_req_d   = req_q;
          out_mask_d  = MASK_OUT_W'(~blocked_q);
          out_tick_d  = tick_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      run_q       <= '0;
      blocked_q   <= '0;
      iss_q       <= 1'b0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      run_q       <= run_d;
      blocked_q   <= blocked_d;
      iss_q       <= iss_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    chk_idx_q  <= chk_idx_d;
    cnt_q      <= cnt_d;
    out_run_q  <= out_run_d;
    out_req_q  <= out_req_d;
    out_mask_q <= out_mask_d;
    out_tick_q <= out_tick_d;
  end

  assign out_valid_o        = out_valid_q;
  assign running_task_o     = out_run_q;
  assign switch_requested_o = out_req_q;
  assign ready_mask_o       = out_mask_q;
  assign tick_now_o         = out_tick_q;

endmodule
`default_nettype wire

[design/rrts_wake_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_wake_ram
// Single-port synchronous RAM holding per-task wake times, registered read.
// ----------------------------------------------------------------------------
module rrts_wake_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

[dv/tb_round_robin_task_scheduler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_round_robin_task_scheduler
// Self-checking bench for the round-robin scheduler: a directed sequence walks
// every event kind, idle-task delays, full blocking and the idle fallback, then
// random event traffic with small delays keeps tasks cycling between blocked
// and ready. A scoreboard predicts every result beat; both sides idle at random.
// ----------------------------------------------------------------------------
module tb_round_robin_task_scheduler;
  import rrts_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 525;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [RUN_OUT_W-1:0]  run;
    logic                  req;
    logic [MASK_OUT_W-1:0] mask;
    tick_t                 tick;
  } sched_result_t;

  class sched_scoreboard;
    tick_t         cur_tick;
    int unsigned   cur_task;
    bit            blocked [TASK_COUNT];
    tick_t         wake_at [TASK_COUNT];
    sched_result_t expected_q[$];
    int unsigned   errors;

    function new();
      cur_tick = '0;
      cur_task = 0;
      errors   = 0;
      for (int i = 0; i < TASK_COUNT; i++) begin
        blocked[i] = 1'b0;
        wake_at[i] = '0;
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void note_event(op_e op, tick_t dly);
      sched_result_t exp_r;
      int unsigned   cand;
      bit            found;
      exp_r.req = 1'b0;
      case (op)
        OP_TICK: begin
          cur_tick = cur_tick + 1;
          for (int i = 1; i < TASK_COUNT; i++)
            if (blocked[i] && wake_at[i] == cur_tick) blocked[i] = 1'b0;
          exp_r.req = 1'b1;
        end
        OP_DELAY: begin
          if (cur_task != 0) begin
            wake_at[cur_task] = cur_tick + dly;
            blocked[cur_task] = 1'b1;
            exp_r.req = 1'b1;
          end
        end
        OP_SWITCH: begin
          cand  = cur_task;
          found = 1'b0;
          for (int n = 0; n < TASK_COUNT; n++) begin
            cand = (cand + 1) % TASK_COUNT;
            if (!found && !blocked[cand]) begin
              cur_task = cand;
              found = 1'b1;
            end
          end
          if (!found) cur_task = 0;
        end
        default: ;
      endcase
      exp_r.run  = RUN_OUT_W'(cur_task);
      exp_r.mask = '0;
      for (int i = 0; i < TASK_COUNT && i < MASK_OUT_W; i++) exp_r.mask[i] = !blocked[i];
      exp_r.tick = cur_tick;
      expected_q.push_back(exp_r);
    endfunction

    function void check_result(logic [RUN_OUT_W-1:0] run, logic req,
                               logic [MASK_OUT_W-1:0] mask, tick_t tick);
      sched_result_t exp_r;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected beat: run=%0d req=%0b mask=%h tick=%0d",
                       run, req, mask, tick));
        return;
      end
      exp_r = expected_q.pop_front();
      if (run !== exp_r.run || req !== exp_r.req || mask !== exp_r.mask ||
          tick !== exp_r.tick)
        flag($sformatf("mismatch: exp run=%0d req=%0b mask=%h tick=%0d, got run=%0d req=%0b mask=%h tick=%0d",
                       exp_r.run, exp_r.req, exp_r.mask, exp_r.tick, run, req, mask, tick));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [OP_W-1:0]       op_i;
  logic [TICK_W-1:0]     delay_ticks_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [RUN_OUT_W-1:0]  running_task_o;
  logic                  switch_requested_o;
  logic [MASK_OUT_W-1:0] ready_mask_o;
  logic [TICK_W-1:0]     tick_now_o;

  sched_scoreboard sb = new();
  bit              hold_out = 1'b0;
  int unsigned     sent = 0;
  int unsigned     cycles = 0;

  round_robin_task_scheduler dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .delay_ticks_i      (delay_ticks_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .running_task_o     (running_task_o),
    .switch_requested_o (switch_requested_o),
    .ready_mask_o       (ready_mask_o),
    .tick_now_o         (tick_now_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(running_task_o, switch_requested_o, ready_mask_o, tick_now_o);
      if (in_valid_i && in_ready_o)
        sb.note_event(op_e'(op_i), delay_ticks_i);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic drive_event(input op_e op, input tick_t dly);
    int unsigned gap;
    gap = (((sent / 50) % 3) == 2) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    op_i          = op;
    delay_ticks_i = dly;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    @(negedge clk_i);
  endtask

  // Result side: random stalls, quiet stretches, one long hold-off on request.
  initial begin : result_sink
    int unsigned beats;
    int unsigned stall;
    out_ready_i = 1'b0;
    beats = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_out) begin
        out_ready_i = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_out = 1'b0;
      end
      stall = (((beats / 60) % 3) == 1) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      beats++;
      @(negedge clk_i);
    end
  end

  initial begin : event_source
    tick_t       task_dly [1:TASK_COUNT-1];
    op_e         op;
    tick_t       dly;
    int unsigned pick;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_TICK;
    delay_ticks_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // unused op, idle-task delays (ignored), first tick
    drive_event(OP_NONE, 32'hFFFF_FFFF);
    drive_event(OP_DELAY, 32'hFFFF_FFFF);
    drive_event(OP_DELAY, 32'h0000_0000);
    drive_event(OP_TICK, 32'h5555_5555);

    // block every real task: zero delay (full wrap), max delay (wraps), short ones
    task_dly[1] = 32'h0000_0000;
    task_dly[2] = 32'hFFFF_FFFF;
    for (int t = 3; t < TASK_COUNT; t++) task_dly[t] = tick_t'((t + 1) / 2);
    for (int t = 1; t < TASK_COUNT; t++) begin
      drive_event(OP_SWITCH, 32'hAAAA_AAAA);
      drive_event(OP_DELAY, task_dly[t]);
    end
    // nothing ready: idle fallback, twice
    drive_event(OP_SWITCH, '0);
    drive_event(OP_SWITCH, '1);
    repeat (4) drive_event(OP_TICK, $urandom());
    drive_event(OP_SWITCH, $urandom());

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) hold_out = 1'b1;
      if (i == 400) begin
        in_valid_i = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = OP_TICK;
      else if (pick < 65) op = OP_DELAY;
      else if (pick < 95) op = OP_SWITCH;
      else                op = OP_NONE;
      dly = $urandom();
      if (op == OP_DELAY && sb.cur_task != 0 && $urandom_range(0, 99) != 0)
        dly = $urandom_range(1, 12);
      drive_event(op, dly);
    end
    in_valid_i = 1'b0;

    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
design/rrts_pkg.sv
design/rrts_wake_ram.sv
design/round_robin_task_scheduler.sv
dv/tb_round_robin_task_scheduler.sv
